// ----- design/uer_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg
// shared types, register indexes and constants of the echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

    // widths of the fixed fields
    localparam int unsigned DistW  = 13;
    localparam int unsigned CountW = 16;
    localparam int unsigned TrigW  = 8;
    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 16;

    // length to distance: (len * 281) >> 10, cm with 4 fraction bits
    localparam int unsigned DistMul   = 281;
    localparam int unsigned DistShift = 10;
    localparam int unsigned ProdW     = CountW + 9;
    localparam int unsigned RawW      = ProdW - DistShift;
    localparam logic [RawW-1:0] DistMin = RawW'(8);
    localparam logic [RawW-1:0] DistMax = RawW'(7200);

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_EMERGENCY_LIMIT = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_SAFE_LIMIT      = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CFG_WAIT_LIMIT      = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CFG_TRIGGER_WIDTH   = CfgIdxW'(3);

    // configuration reset values
    localparam logic [DistW-1:0]  EmergencyReset = DistW'(320);
    localparam logic [DistW-1:0]  SafeReset      = DistW'(800);
    localparam logic [CountW-1:0] WaitReset      = CountW'(30000);
    localparam logic [TrigW-1:0]  TrigReset      = TrigW'(12);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_RISE = 2'd2,
        PH_HIGH = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CLS_INVALID   = 2'd0,
        CLS_EMERGENCY = 2'd1,
        CLS_SAFE      = 2'd2,
        CLS_FAR       = 2'd3
    } t_range_class;

    // what one tick of the sequencer produces
    typedef struct packed {
        t_phase            phase_next;
        logic              done;
        logic              pulse_end;
        logic [CountW-1:0] pulse_len;
    } t_fsm_step;

    // converted and classed pulse
    typedef struct packed {
        logic             ok;
        logic [DistW-1:0] dist_q4;
        t_range_class     cls;
    } t_range_res;

endpackage
`default_nettype wire

// ----- design/ultrasonic_echo_ranger_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// ultrasonic ranging controller: trigger pulse, echo timing, distance, class
// ----------------------------------------------------------------------------
// result: a result word is valid in the cycle after its input word is accepted
// throughput: one input word per cycle unless a held result word stalls the input,
//   set by the sequencer step plus one 16x9 multiply between the state and the result register
// reset: synchronous active low; idle phase, count zero, last distance zero,
//   class invalid, limits back to 320 / 800 / 30000 ticks / 12 ticks
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input words, one per microsecond tick
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire logic                            i_start_request,
    input  wire logic                            i_echo_level,
    // result words
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output      logic                            o_trigger_level,
    output      logic                            o_busy_res,
    output      logic                            o_done_res,
    output      logic [uer_pkg::DistW-1:0]       o_distance_q4,
    output      logic [1:0]                      o_range_class,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [uer_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [uer_pkg::CfgDataW-1:0]    i_cfg_data
);

    // configuration registers
    logic [uer_pkg::DistW-1:0]  r_emergency_limit;
    logic [uer_pkg::DistW-1:0]  r_safe_limit;
    logic [uer_pkg::CountW-1:0] r_wait_limit;
    logic [uer_pkg::TrigW-1:0]  r_trig_width;

    // last measurement, kept until the next one finishes
    logic [uer_pkg::DistW-1:0]  r_last_dist, n_last_dist;
    uer_pkg::t_range_class      r_last_cls, n_last_cls;

    // output register
    logic                       r_out_valid;
    logic                       r_trigger, r_busy, r_done;
    logic [uer_pkg::DistW-1:0]  r_dist;
    uer_pkg::t_range_class      r_cls;

    logic                       w_in_acc;
    uer_pkg::t_fsm_step         w_step;
    uer_pkg::t_range_res        w_range;

    // the output register frees itself whenever the far side takes its word,
    // so a word can enter in the same cycle as the previous one leaves
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // config writes take effect at once; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emergency_limit <= uer_pkg::EmergencyReset;
            r_safe_limit      <= uer_pkg::SafeReset;
            r_wait_limit      <= uer_pkg::WaitReset;
            r_trig_width      <= uer_pkg::TrigReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                uer_pkg::CFG_EMERGENCY_LIMIT: r_emergency_limit <= i_cfg_data[uer_pkg::DistW-1:0];
                uer_pkg::CFG_SAFE_LIMIT:      r_safe_limit      <= i_cfg_data[uer_pkg::DistW-1:0];
                uer_pkg::CFG_WAIT_LIMIT:      r_wait_limit      <= i_cfg_data[uer_pkg::CountW-1:0];
                uer_pkg::CFG_TRIGGER_WIDTH:   r_trig_width      <= i_cfg_data[uer_pkg::TrigW-1:0];
                default: ;
            endcase
        end
    end

    // phase sequencer, steps once per accepted word
    uer_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_in_acc),
        .i_start      (i_start_request),
        .i_echo       (i_echo_level),
        .i_trig_width (r_trig_width),
        .i_wait_limit (r_wait_limit),
        .o_step       (w_step)
    );

    // distance from the counted pulse length
    uer_range u_range (
        .i_len             (w_step.pulse_len),
        .i_emergency_limit (r_emergency_limit),
        .i_safe_limit      (r_safe_limit),
        .o_res             (w_range)
    );

    // a finish on timeout or an out-of-range pulse both clear the last value
    always_comb begin
        n_last_dist = r_last_dist;
        n_last_cls  = r_last_cls;
        if (w_step.done) begin
            if (w_step.pulse_end) begin
                n_last_dist = w_range.dist_q4;
                n_last_cls  = w_range.cls;
            end else begin
                n_last_dist = '0;
                n_last_cls  = uer_pkg::CLS_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_dist <= '0;
            r_last_cls  <= uer_pkg::CLS_INVALID;
        end else if (w_in_acc) begin
            r_last_dist <= n_last_dist;
            r_last_cls  <= n_last_cls;
        end
    end

    // result word shows the state after the tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_trigger <= (w_step.phase_next == uer_pkg::PH_TRIG);
            r_busy    <= (w_step.phase_next != uer_pkg::PH_IDLE);
            r_done    <= w_step.done;
            r_dist    <= n_last_dist;
            r_cls     <= n_last_cls;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trigger_level = r_trigger;
    assign o_busy_res      = r_busy;
    assign o_done_res      = r_done;
    assign o_distance_q4   = r_dist;
    assign o_range_class   = r_cls;

endmodule
`default_nettype wire

// ----- design/uer_fsm.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_fsm
// trigger / echo wait / pulse timing sequencer, one step per accepted word
// ----------------------------------------------------------------------------
module uer_fsm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_start,
    input  wire logic                          i_echo,
    input  wire logic [uer_pkg::TrigW-1:0]     i_trig_width,
    input  wire logic [uer_pkg::CountW-1:0]    i_wait_limit,
    output uer_pkg::t_fsm_step                 o_step
);

    uer_pkg::t_phase              r_phase, n_phase;
    logic [uer_pkg::CountW-1:0]   r_count, n_count;
    logic                         w_trig_end;
    logic                         w_timeout;

    assign w_trig_end = r_count >= uer_pkg::CountW'(i_trig_width);
    assign w_timeout  = r_count >= i_wait_limit;

    // next state
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            uer_pkg::PH_IDLE: begin
                if (i_start) n_phase = uer_pkg::PH_TRIG;
            end
            uer_pkg::PH_TRIG: begin
                if (w_trig_end) n_phase = uer_pkg::PH_RISE;
            end
            uer_pkg::PH_RISE: begin
                if (i_echo) n_phase = uer_pkg::PH_HIGH;
                else if (w_timeout) n_phase = uer_pkg::PH_IDLE;
            end
            uer_pkg::PH_HIGH: begin
                if (!i_echo || w_timeout) n_phase = uer_pkg::PH_IDLE;
            end
            default: n_phase = uer_pkg::PH_IDLE;
        endcase
    end

    // counter and finish flags
    always_comb begin
        n_count          = r_count + uer_pkg::CountW'(1);
        o_step.done      = 1'b0;
        o_step.pulse_end = 1'b0;
        case (r_phase)
            uer_pkg::PH_IDLE: begin
                n_count = i_start ? uer_pkg::CountW'(1) : '0;
            end
            uer_pkg::PH_TRIG: begin
                if (w_trig_end) n_count = '0;
            end
            uer_pkg::PH_RISE: begin
                if (i_echo) begin
                    n_count = uer_pkg::CountW'(1);
                end else if (w_timeout) begin
                    n_count     = '0;
                    o_step.done = 1'b1;
                end
            end
            uer_pkg::PH_HIGH: begin
                if (!i_echo) begin
                    n_count          = '0;
                    o_step.done      = 1'b1;
                    o_step.pulse_end = 1'b1;
                end else if (w_timeout) begin
                    n_count     = '0;
                    o_step.done = 1'b1;
                end
            end
            default: n_count = '0;
        endcase
        o_step.phase_next = n_phase;
        o_step.pulse_len  = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uer_pkg::PH_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- design/uer_range.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_range
// pulse length to distance, range check and class against the two limits
// ----------------------------------------------------------------------------
module uer_range (
    input  wire logic [uer_pkg::CountW-1:0] i_len,
    input  wire logic [uer_pkg::DistW-1:0]  i_emergency_limit,
    input  wire logic [uer_pkg::DistW-1:0]  i_safe_limit,
    output uer_pkg::t_range_res             o_res
);

    logic [uer_pkg::ProdW-1:0] w_prod;
    logic [uer_pkg::RawW-1:0]  w_raw;
    logic [uer_pkg::DistW-1:0] w_dist;

    assign w_prod = uer_pkg::ProdW'(i_len) * uer_pkg::ProdW'(uer_pkg::DistMul);
    assign w_raw  = w_prod[uer_pkg::ProdW-1:uer_pkg::DistShift];
    assign w_dist = w_raw[uer_pkg::DistW-1:0];

    always_comb begin
        o_res.ok = (w_raw >= uer_pkg::DistMin) && (w_raw <= uer_pkg::DistMax);
        if (!o_res.ok) begin
            o_res.dist_q4 = '0;
            o_res.cls     = uer_pkg::CLS_INVALID;
        end else begin
            o_res.dist_q4 = w_dist;
            if (w_dist < i_emergency_limit) o_res.cls = uer_pkg::CLS_EMERGENCY;
            else if (w_dist <= i_safe_limit) o_res.cls = uer_pkg::CLS_SAFE;
            else o_res.cls = uer_pkg::CLS_FAR;
        end
    end

endmodule
`default_nettype wire

// ----- design/uer_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_checker
// port-level checks of the echo ranger result stream
// ----------------------------------------------------------------------------
module uer_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire logic                      o_trigger_level,
    input wire logic                      o_busy_res,
    input wire logic                      o_done_res,
    input wire logic [uer_pkg::DistW-1:0] o_distance_q4,
    input wire logic [1:0]                o_range_class
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_distance_q4) && $stable(o_range_class)
            && $stable(o_done_res))
        else $error("result word changed while stalled");

    // a finished measurement leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    // trigger only during a measurement
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_trigger_level |-> o_busy_res)
        else $error("trigger high while idle");

    // invalid class carries zero distance
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_range_class == uer_pkg::CLS_INVALID) |-> o_distance_q4 == '0)
        else $error("invalid class with nonzero distance");

    // a valid distance lies in the sensor range
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_range_class != uer_pkg::CLS_INVALID) |->
            (o_distance_q4 >= uer_pkg::DistW'(8)) && (o_distance_q4 <= uer_pkg::DistW'(7200)))
        else $error("classed distance out of range");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_trigger_level (o_trigger_level),
    .o_busy_res      (o_busy_res),
    .o_done_res      (o_done_res),
    .o_distance_q4   (o_distance_q4),
    .o_range_class   (o_range_class)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ultrasonic echo ranger: every tick word in
// produces one status word out, compared field by field against an
// in-bench tick model; directed ranging cases first, then random ones
// ----------------------------------------------------------------------------
module tb_top;
    import uer_pkg::*;

    // echo length to distance limits, cm with 4 fraction bits
    localparam int unsigned QMin = 8;
    localparam int unsigned QMax = 7200;
    // random tick words wanted after the directed rows
    localparam int unsigned RandTicks = 900;
    // cycles without any word moving before the run is declared hung
    localparam int unsigned QuietLimit = 2000;

    // one status word as seen on the result channel
    typedef struct packed {
        logic             trig;
        logic             busy;
        logic             done;
        logic [DistW-1:0] dist_q4;
        t_range_class     cls;
    } t_status;

    // directed rows: a register write, a run of idle ticks, or one ranging
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_IDLE,
        ROW_RANGE
    } t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CfgIdxW-1:0]   idx;
        logic [CfgDataW-1:0]  val;
        int unsigned          gap;
        int unsigned          len;
        int unsigned          start_pct;
        logic                 pinned;
        logic [DistW-1:0]     dist_q4;
        t_range_class         cls;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 i_start_request = 1'b0;
    logic                 i_echo_level = 1'b0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_index = '0;
    logic [CfgDataW-1:0]  i_cfg_data = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_trigger_level;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic [DistW-1:0]     o_distance_q4;
    logic [1:0]           o_range_class;
    logic                 o_cfg_ready;

    ultrasonic_echo_ranger_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_request (i_start_request),
        .i_echo_level    (i_echo_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_trigger_level (o_trigger_level),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_distance_q4   (o_distance_q4),
        .o_range_class   (o_range_class),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ranger model state and its copy of the registers
    t_phase             m_phase;
    logic [CountW-1:0]  m_count;
    logic [DistW-1:0]   m_dist;
    t_range_class       m_cls;
    logic [DistW-1:0]   m_emerg;
    logic [DistW-1:0]   m_safe;
    logic [CountW-1:0]  m_wait;
    logic [TrigW-1:0]   m_trig;

    t_status      status_due[$];   // status words still owed by the block
    t_row         plan[$];         // directed rows, walked in order
    t_status      got;
    int unsigned  n_bad = 0;
    int unsigned  n_sent = 0;
    int unsigned  quiet = 0;
    int unsigned  rx_hold = 0;
    logic         tx_idle_on = 1'b1;
    logic         rx_idle_on = 1'b1;
    // a directed row may pin the distance and class of its last status word
    logic             pin_on = 1'b0;
    logic [DistW-1:0] pin_dist;
    t_range_class     pin_cls;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // tick model
    // ------------------------------------------------------------------

    function automatic void ranger_clear();
        m_phase = PH_IDLE;
        m_count = '0;
        m_dist  = '0;
        m_cls   = CLS_INVALID;
    endfunction

    // one microsecond tick: advance the model, return the status after it
    function automatic void ranger_tick(input logic s, input logic e, output t_status w);
        int unsigned q4;
        w.done = 1'b0;
        case (m_phase)
            PH_IDLE: begin
                if (s) begin
                    m_phase = PH_TRIG;
                    m_count = 16'd1;
                end
            end
            PH_TRIG: begin
                // zero width behaves like one: the start tick alone is high
                if (m_count >= m_trig) begin
                    m_phase = PH_RISE;
                    m_count = '0;
                end else begin
                    m_count = m_count + 16'd1;
                end
            end
            PH_RISE: begin
                if (e) begin
                    // the rising tick is already the first tick of the pulse
                    m_phase = PH_HIGH;
                    m_count = 16'd1;
                end else if (m_count >= m_wait) begin
                    ranger_clear();
                    w.done = 1'b1;
                end else begin
                    m_count = m_count + 16'd1;
                end
            end
            default: begin
                if (!e) begin
                    q4 = (32'(m_count) * DistMul) >> DistShift;
                    if (q4 < QMin || q4 > QMax) begin
                        ranger_clear();
                    end else begin
                        m_dist = DistW'(q4);
                        // tested in this order even when the limits cross
                        if (q4 < m_emerg)
                            m_cls = CLS_EMERGENCY;
                        else if (q4 <= m_safe)
                            m_cls = CLS_SAFE;
                        else
                            m_cls = CLS_FAR;
                        m_phase = PH_IDLE;
                        m_count = '0;
                    end
                    w.done = 1'b1;
                end else if (m_count >= m_wait) begin
                    ranger_clear();
                    w.done = 1'b1;
                end else begin
                    m_count = m_count + 16'd1;
                end
            end
        endcase
        w.trig    = (m_phase == PH_TRIG);
        w.busy    = (m_phase != PH_IDLE);
        w.dist_q4 = m_dist;
        w.cls     = m_cls;
    endfunction

    // ------------------------------------------------------------------
    // drivers; every task is entered and left in the step of a rising edge
    // ------------------------------------------------------------------

    // present one tick word, hold it until taken, then maybe go quiet
    task automatic send_tick(input logic s, input logic e);
        t_status w;
        i_in_valid      <= 1'b1;
        i_start_request <= s;
        i_echo_level    <= e;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        ranger_tick(s, e, w);
        if (pin_on) begin
            w.dist_q4 = pin_dist;
            w.cls     = pin_cls;
            pin_on    = 1'b0;
        end
        status_due.push_back(w);
        n_sent++;
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every owed status word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_EMERGENCY_LIMIT: m_emerg = val[DistW-1:0];
            CFG_SAFE_LIMIT:      m_safe  = val[DistW-1:0];
            CFG_WAIT_LIMIT:      m_wait  = val;
            CFG_TRIGGER_WIDTH:   m_trig  = val[TrigW-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one ranging: start, trigger ticks, echo low for gap ticks, echo high
    // for len ticks, then the falling tick if len is nonzero; without do_start only idle ticks
    task automatic run_ranging(input logic do_start, input int unsigned gap,
                               input int unsigned len, input int unsigned start_pct,
                               input logic pinned, input logic [DistW-1:0] dist_q4,
                               input t_range_class cls);
        logic [1:0]  seq[$];
        int unsigned tw;
        tw = (m_trig == 0) ? 1 : m_trig;
        if (!do_start) begin
            repeat (gap) seq.push_back({1'b0, ($urandom & 1) != 0});
        end else begin
            seq.push_back({1'b1, ($urandom & 1) != 0});
            // echo is not looked at while the trigger is high
            repeat (tw) seq.push_back({$urandom_range(0, 99) < start_pct, ($urandom & 1) != 0});
            repeat (gap) seq.push_back({$urandom_range(0, 99) < start_pct, 1'b0});
            repeat (len) seq.push_back({$urandom_range(0, 99) < start_pct, 1'b1});
            if (len != 0)
                seq.push_back({$urandom_range(0, 99) < start_pct, 1'b0});
        end
        foreach (seq[k]) begin
            if (k == seq.size() - 1) begin
                pin_on   = pinned;
                pin_dist = dist_q4;
                pin_cls  = cls;
            end
            send_tick(seq[k][1], seq[k][0]);
        end
    endtask

    function automatic int unsigned pick_limit();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return QMax;
            2:       return $urandom_range(0, QMax);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // new register values; spare data bits above each register are random
    task automatic random_setup();
        int unsigned v;
        drain();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1: write_reg(CFG_EMERGENCY_LIMIT,
                                {3'($urandom_range(0, 7)), 13'(pick_limit())});
                2, 3: write_reg(CFG_SAFE_LIMIT,
                                {3'($urandom_range(0, 7)), 13'(pick_limit())});
                4, 5, 6: begin
                    case ($urandom_range(0, 19))
                        0:       v = 0;
                        1:       v = 1;
                        2:       v = 65535;
                        default: v = $urandom_range(2, 150);
                    endcase
                    write_reg(CFG_WAIT_LIMIT, 16'(v));
                end
                7, 8: begin
                    case ($urandom_range(0, 9))
                        0:       v = 0;
                        1:       v = 1;
                        2:       v = 255;
                        default: v = $urandom_range(2, 16);
                    endcase
                    write_reg(CFG_TRIGGER_WIDTH, {8'($urandom_range(0, 255)), 8'(v)});
                end
                // unmapped index, must leave every register alone
                default: write_reg(CfgIdxW'($urandom_range(CFG_TRIGGER_WIDTH + 1, 255)),
                                   16'($urandom_range(0, 65535)));
            endcase
        end
    endtask

    function automatic void add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        t_row r;
        r = '{ROW_CFG, idx, val, 0, 0, 0, 1'b0, '0, CLS_INVALID};
        plan.push_back(r);
    endfunction

    function automatic void add_meas(input t_row_kind kind, input int unsigned gap,
                                     input int unsigned len, input int unsigned start_pct,
                                     input logic pinned, input int unsigned dist_q4,
                                     input t_range_class cls);
        t_row r;
        r = '{kind, '0, '0, gap, len, start_pct, pinned, DistW'(dist_q4), cls};
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall bursts, then compare each taken word
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold     <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_hold     <= $urandom_range(0, 8);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (status_due.size() == 0) begin
                $error("status word with nothing owed");
                n_bad++;
            end else begin
                got = status_due.pop_front();
                if (o_trigger_level !== got.trig) begin
                    $error("trigger_level: expected %0d, got %0d", got.trig, o_trigger_level);
                    n_bad++;
                end
                if (o_busy_res !== got.busy) begin
                    $error("busy_res: expected %0d, got %0d", got.busy, o_busy_res);
                    n_bad++;
                end
                if (o_done_res !== got.done) begin
                    $error("done_res: expected %0d, got %0d", got.done, o_done_res);
                    n_bad++;
                end
                if (o_distance_q4 !== got.dist_q4) begin
                    $error("distance_q4: expected %0d, got %0d", got.dist_q4, o_distance_q4);
                    n_bad++;
                end
                if (o_range_class !== got.cls) begin
                    $error("range_class: expected %0d, got %0d", got.cls, o_range_class);
                    n_bad++;
                end
            end
        end
    end

    // hang detector: any word moving on any channel resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)
            || (i_cfg_valid && o_cfg_ready === 1'b1))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QuietLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        int unsigned cap;
        int unsigned gap;
        int unsigned len;
        int unsigned spct;
        int unsigned base_sent;

        ranger_clear();
        m_emerg = 13'd320;
        m_safe  = 13'd800;
        m_wait  = 16'd30000;
        m_trig  = 8'd12;

        // reset limits: emergency below 320, safe up to 800, far above
        add_meas(ROW_IDLE,   3, 0, 0, 1'b1, 0, CLS_INVALID);       // state right after reset
        add_meas(ROW_RANGE,  3, 30, 0, 1'b1, 8, CLS_EMERGENCY);    // shortest valid echo
        add_meas(ROW_RANGE,  0, 29, 0, 1'b1, 0, CLS_INVALID);      // just under half a cm
        // class edges on short echoes: emergency below 20, safe up to 30
        add_cfg(CFG_EMERGENCY_LIMIT, 16'd20);
        add_cfg(CFG_SAFE_LIMIT, 16'd30);
        add_meas(ROW_RANGE,  5, 72, 100, 1'b0, 0, CLS_INVALID);    // start held while busy
        add_meas(ROW_RANGE,  1, 73, 0, 1'b0, 0, CLS_INVALID);
        add_meas(ROW_RANGE,  2, 112, 0, 1'b0, 0, CLS_INVALID);
        add_meas(ROW_RANGE,  2, 113, 0, 1'b0, 0, CLS_INVALID);
        // short edge waits: both timeouts, right at and past the limit
        add_cfg(CFG_WAIT_LIMIT, 16'd40);
        add_meas(ROW_RANGE, 40, 40, 0, 1'b1, 10, CLS_EMERGENCY);
        add_meas(ROW_RANGE,  2, 41, 0, 1'b1, 0, CLS_INVALID);
        add_meas(ROW_RANGE, 41, 0, 0, 1'b1, 0, CLS_INVALID);
        // zero wait: no echo gives up at once, a high echo dies on its next tick
        add_cfg(CFG_WAIT_LIMIT, 16'd0);
        add_meas(ROW_RANGE,  0, 2, 0, 1'b1, 0, CLS_INVALID);
        add_meas(ROW_RANGE,  1, 0, 0, 1'b1, 0, CLS_INVALID);
        add_cfg(CFG_WAIT_LIMIT, 16'hFFFF);
        // trigger width of zero and of its maximum
        add_cfg(CFG_TRIGGER_WIDTH, 16'd0);
        add_meas(ROW_RANGE,  0, 30, 0, 1'b1, 8, CLS_EMERGENCY);
        add_cfg(CFG_TRIGGER_WIDTH, 16'd255);
        add_meas(ROW_RANGE,  2, 30, 0, 1'b1, 8, CLS_EMERGENCY);
        add_cfg(CFG_TRIGGER_WIDTH, 16'd1);
        // crossed limits keep the emergency, safe, far test order
        add_cfg(CFG_EMERGENCY_LIMIT, 16'd7200);
        add_cfg(CFG_SAFE_LIMIT, 16'd0);
        add_meas(ROW_RANGE,  4, 31, 0, 1'b1, 8, CLS_EMERGENCY);
        add_cfg(CFG_EMERGENCY_LIMIT, 16'd0);
        add_meas(ROW_RANGE,  1, 30, 0, 1'b1, 8, CLS_FAR);
        add_cfg(CFG_SAFE_LIMIT, 16'd7200);
        add_meas(ROW_RANGE,  1, 33, 0, 1'b1, 9, CLS_SAFE);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows; registers only change once every word is back
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                drain();
                write_reg(plan[r].idx, plan[r].val);
            end else begin
                run_ranging(plan[r].kind == ROW_RANGE, plan[r].gap, plan[r].len,
                            plan[r].start_pct, plan[r].pinned, plan[r].dist_q4, plan[r].cls);
            end
        end

        // random part: mostly well formed rangings with random timing,
        // some pure noise, and register changes between them
        base_sent = n_sent;
        random_setup();
        while (n_sent - base_sent < RandTicks) begin
            if (n_sent - base_sent >= RandTicks - 300) begin
                // closing stretch runs at full rate on both sides
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                tx_idle_on = ($urandom & 1) != 0;
                rx_idle_on = ($urandom & 1) != 0;
            end
            case ($urandom_range(0, 9))
                0: random_setup();
                1: repeat ($urandom_range(1, 20))
                       send_tick(($urandom & 1) != 0, ($urandom & 1) != 0);
                default: begin
                    cap = (m_wait < 120) ? m_wait : 120;
                    if ($urandom_range(0, 9) == 0 && m_wait <= 120)
                        gap = m_wait + 1;                         // no echo in time
                    else
                        gap = $urandom_range(0, (cap < 20) ? cap : 20);
                    case ($urandom_range(0, 9))
                        0:       len = (m_wait <= 120) ? m_wait + 1 : cap;  // echo too long when m_wait <= 120
                        1:       len = $urandom_range(0, 29);              // too close
                        default: len = $urandom_range((cap < 30) ? 0 : 30, cap);
                    endcase
                    spct = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
                    run_ranging(1'b1, gap, len, spct, 1'b0, 0, CLS_INVALID);
                end
            endcase
        end

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        drain();
        // a few more cycles to catch any stray status word
        repeat (4) @(posedge i_clk);
        if (n_bad == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/uer_pkg.sv
design/uer_fsm.sv
design/uer_range.sv
design/ultrasonic_echo_ranger_unit.sv
design/uer_checker.sv
tb/tb_top.sv
